// ----- rtl/core/dsrc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared types and constants of the subordinate id range calculator.
// ----------------------------------------------------------------------------
package dsrc_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SPACE_W   = DATA_W + 1;
  localparam int NUM_CELLS = PROD_W;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [DATA_W-1:0] USER_ID_MIN_RST  = 32'd1000;
  localparam logic [DATA_W-1:0] SUB_ID_MIN_RST   = 32'd65536;
  localparam logic [DATA_W-1:0] SUB_ID_MAX_RST   = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] IDS_PER_USER_RST = 32'd65536;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BELOW_MIN  = 3'd1,
    ST_BAD_CONFIG = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_PAST_MAX   = 3'd5
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_USER_ID_MIN  = 3'd0,
    REG_SUB_ID_MIN   = 3'd1,
    REG_SUB_ID_MAX   = 3'd2,
    REG_IDS_PER_USER = 3'd3,
    REG_WRAP_ENABLE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              vld;
    status_t           st;
    logic [PROD_W-1:0] product;
  } prod_t;

  typedef struct packed {
    logic              vld;
    status_t           st;
    logic [DATA_W-1:0] rem;
    logic [PROD_W-1:0] dvd;
  } cell_t;

  typedef struct packed {
    logic              vld;
    status_t           st;
    logic [DATA_W-1:0] first;
  } result_t;

endpackage

// ----- rtl/core/dsrc_front.sv -----
// ----------------------------------------------------------------------------
// dsrc_front
// Request checks, offset computation and the offset times range size product.
// ----------------------------------------------------------------------------
module dsrc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [dsrc_pkg::DATA_W-1:0]   user_id,
  input  logic [dsrc_pkg::DATA_W-1:0]   user_id_min,
  input  logic [dsrc_pkg::DATA_W-1:0]   sub_id_min,
  input  logic [dsrc_pkg::DATA_W-1:0]   sub_id_max,
  input  logic [dsrc_pkg::DATA_W-1:0]   ids_per_user,
  input  logic [dsrc_pkg::SPACE_W-1:0]  space,
  output dsrc_pkg::prod_t               prod
);

  logic                        vld1;
  dsrc_pkg::status_t           st1;
  dsrc_pkg::status_t           st1_next;
  logic [dsrc_pkg::DATA_W-1:0] offset;

  always_comb begin
    if (user_id < user_id_min) begin
      st1_next = dsrc_pkg::ST_BELOW_MIN;
    end else if ((sub_id_min > sub_id_max) || (ids_per_user == '0)) begin
      st1_next = dsrc_pkg::ST_BAD_CONFIG;
    end else if ({1'b0, ids_per_user} > space) begin
      st1_next = dsrc_pkg::ST_NO_SPACE;
    end else begin
      st1_next = dsrc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1     <= 1'b0;
      prod.vld <= 1'b0;
    end else begin
      vld1     <= accept;
      prod.vld <= vld1;
    end
    st1          <= st1_next;
    offset       <= user_id - user_id_min;
    prod.st      <= st1;
    prod.product <= dsrc_pkg::PROD_W'(offset) * dsrc_pkg::PROD_W'(ids_per_user);
  end

endmodule

// ----- rtl/core/dsrc_safe.sv -----
// ----------------------------------------------------------------------------
// dsrc_safe
// Overflow and range end checks for the non-wrapping mode.
// ----------------------------------------------------------------------------
module dsrc_safe #(
  parameter int ID_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dsrc_pkg::prod_t             prod,
  input  logic [dsrc_pkg::DATA_W-1:0] sub_id_min,
  input  logic [dsrc_pkg::DATA_W-1:0] sub_id_max,
  input  logic [dsrc_pkg::DATA_W-1:0] ids_per_user,
  output dsrc_pkg::result_t           res
);

  logic                         vld3;
  dsrc_pkg::status_t            st3;
  logic                         prod_ovf;
  logic [dsrc_pkg::SPACE_W-1:0] first;
  logic [dsrc_pkg::SPACE_W:0]   last;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= prod.vld;
    end
  end

  always_ff @(posedge clk) begin
    st3      <= prod.st;
    prod_ovf <= |(prod.product >> ID_WIDTH);
    first    <= {1'b0, sub_id_min} + {1'b0, prod.product[dsrc_pkg::DATA_W-1:0]};
  end

  always_comb begin
    last      = {1'b0, first} + {2'b00, ids_per_user} - (dsrc_pkg::SPACE_W + 1)'(1);
    res.vld   = vld3;
    res.first = first[dsrc_pkg::DATA_W-1:0];
    if (st3 != dsrc_pkg::ST_OK) begin
      res.st = st3;
    end else if (prod_ovf || (|(first >> ID_WIDTH)) || (|(last >> ID_WIDTH))) begin
      res.st = dsrc_pkg::ST_OVERFLOW;
    end else if (last > {2'b00, sub_id_max}) begin
      res.st = dsrc_pkg::ST_PAST_MAX;
    end else begin
      res.st = dsrc_pkg::ST_OK;
    end
  end

endmodule

// ----- rtl/core/dsrc_mod_cell.sv -----
// ----------------------------------------------------------------------------
// dsrc_mod_cell
// One restoring step of the product modulo space reduction.
// ----------------------------------------------------------------------------
module dsrc_mod_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [dsrc_pkg::SPACE_W-1:0] space,
  input  dsrc_pkg::cell_t              din,
  output dsrc_pkg::cell_t              dout
);

  logic [dsrc_pkg::SPACE_W-1:0] shifted;
  logic [dsrc_pkg::SPACE_W-1:0] diff;

  always_comb begin
    shifted = {din.rem, din.dvd[dsrc_pkg::PROD_W-1]};
    diff    = shifted - space;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.st  <= din.st;
    dout.dvd <= din.dvd << 1;
    if (shifted >= space) begin
      dout.rem <= diff[dsrc_pkg::DATA_W-1:0];
    end else begin
      dout.rem <= shifted[dsrc_pkg::DATA_W-1:0];
    end
  end

endmodule

// ----- rtl/core/deterministic_subid_range_calc_top.sv -----
// ----------------------------------------------------------------------------
// deterministic_subid_range_calc_top
// Maps a user id to a fixed-size subordinate id range, one request per cycle.
// ----------------------------------------------------------------------------
// Throughput is one transaction per cycle; busy stays low.
// Safe mode results pass the front, safe check and output registers; wrap
// mode ones pass the front registers, 64 one-bit modulo cells and output.
// Reset clears the pipeline valids and loads the register defaults.
module deterministic_subid_range_calc_top #(
  parameter int ID_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dsrc_pkg::DATA_W-1:0]  user_id,
  output logic                         busy,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [dsrc_pkg::DATA_W-1:0]  range_first,
  output logic [dsrc_pkg::DATA_W-1:0]  range_size,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dsrc_pkg::DATA_W-1:0]  pwdata,
  output logic [dsrc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [dsrc_pkg::DATA_W-1:0]  user_id_min;
  logic [dsrc_pkg::DATA_W-1:0]  sub_id_min;
  logic [dsrc_pkg::DATA_W-1:0]  sub_id_max;
  logic [dsrc_pkg::DATA_W-1:0]  ids_per_user;
  logic                         wrap_enable;
  logic [dsrc_pkg::SPACE_W-1:0] space_next;
  logic [dsrc_pkg::SPACE_W-1:0] space;
  dsrc_pkg::reg_idx_t           reg_idx;
  logic                         cfg_wr;
  dsrc_pkg::prod_t              prod;
  dsrc_pkg::result_t            safe_res;
  dsrc_pkg::result_t            sel_res;
  dsrc_pkg::cell_t              links [dsrc_pkg::NUM_CELLS+1];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = dsrc_pkg::reg_idx_t'(paddr[dsrc_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_id_min  <= dsrc_pkg::USER_ID_MIN_RST;
      sub_id_min   <= dsrc_pkg::SUB_ID_MIN_RST;
      sub_id_max   <= dsrc_pkg::SUB_ID_MAX_RST;
      ids_per_user <= dsrc_pkg::IDS_PER_USER_RST;
      wrap_enable  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dsrc_pkg::REG_USER_ID_MIN:  user_id_min  <= pwdata;
        dsrc_pkg::REG_SUB_ID_MIN:   sub_id_min   <= pwdata;
        dsrc_pkg::REG_SUB_ID_MAX:   sub_id_max   <= pwdata;
        dsrc_pkg::REG_IDS_PER_USER: ids_per_user <= pwdata;
        dsrc_pkg::REG_WRAP_ENABLE:  wrap_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dsrc_pkg::REG_USER_ID_MIN:  prdata = user_id_min;
      dsrc_pkg::REG_SUB_ID_MIN:   prdata = sub_id_min;
      dsrc_pkg::REG_SUB_ID_MAX:   prdata = sub_id_max;
      dsrc_pkg::REG_IDS_PER_USER: prdata = ids_per_user;
      dsrc_pkg::REG_WRAP_ENABLE:  prdata = {{(dsrc_pkg::DATA_W-1){1'b0}}, wrap_enable};
      default:                    prdata = '0;
    endcase
  end

  assign space_next = {1'b0, sub_id_max} - {1'b0, sub_id_min} + dsrc_pkg::SPACE_W'(1);

  always_ff @(posedge clk) begin
    space <= space_next;
  end

  dsrc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (start && !busy),
    .user_id      (user_id),
    .user_id_min  (user_id_min),
    .sub_id_min   (sub_id_min),
    .sub_id_max   (sub_id_max),
    .ids_per_user (ids_per_user),
    .space        (space_next),
    .prod         (prod)
  );

  dsrc_safe #(
    .ID_WIDTH (ID_WIDTH)
  ) u_safe (
    .clk          (clk),
    .rst          (rst),
    .prod         (prod),
    .sub_id_min   (sub_id_min),
    .sub_id_max   (sub_id_max),
    .ids_per_user (ids_per_user),
    .res          (safe_res)
  );

  always_comb begin
    links[0].vld = prod.vld && wrap_enable;
    links[0].st  = prod.st;
    links[0].rem = '0;
    links[0].dvd = prod.product;
  end

  for (genvar i = 0; i < dsrc_pkg::NUM_CELLS; i++) begin : g_cell
    dsrc_mod_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .space (space),
      .din   (links[i]),
      .dout  (links[i+1])
    );
  end

  always_comb begin
    if (wrap_enable) begin
      sel_res.vld   = links[dsrc_pkg::NUM_CELLS].vld;
      sel_res.st    = links[dsrc_pkg::NUM_CELLS].st;
      sel_res.first = sub_id_min + links[dsrc_pkg::NUM_CELLS].rem;
    end else begin
      sel_res = safe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sel_res.vld;
    end
  end

  always_ff @(posedge clk) begin
    status <= sel_res.st;
    if (sel_res.st == dsrc_pkg::ST_OK) begin
      range_first <= sel_res.first;
      range_size  <= ids_per_user;
    end else begin
      range_first <= '0;
      range_size  <= '0;
    end
  end

endmodule

// ----- rtl/core/dsrc_checker.sv -----
// ----------------------------------------------------------------------------
// dsrc_checker
// Port-level checks of the result transactions, bound to the top level.
// ----------------------------------------------------------------------------
module dsrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] range_first,
  input logic [31:0] range_size
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != dsrc_pkg::ST_OK)) |-> ((range_first == '0) && (range_size == '0)))
    else $error("Error result carries a nonzero range.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == dsrc_pkg::ST_OK) || (status == dsrc_pkg::ST_BELOW_MIN) ||
              (status == dsrc_pkg::ST_BAD_CONFIG) || (status == dsrc_pkg::ST_NO_SPACE) ||
              (status == dsrc_pkg::ST_OVERFLOW) || (status == dsrc_pkg::ST_PAST_MAX)))
    else $error("Result status is not a defined code.");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    (done && (status == dsrc_pkg::ST_OK)) |-> (range_size != '0))
    else $error("Successful result has an empty range.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("Result strobe right after reset.");

endmodule

bind deterministic_subid_range_calc_top dsrc_checker u_dsrc_checker (
  .clk         (clk),
  .rst         (rst),
  .done        (done),
  .status      (status),
  .range_first (range_first),
  .range_size  (range_size)
);
